>>> rtl/core/idc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Interrupt dispatch controller package
// Shared types, codes and constants of the interrupt dispatch controller.
// ----------------------------------------------------------------------------
package idc_pkg;

    localparam int unsigned CMP_W     = 32;
    localparam int unsigned HND_W     = 32;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned CNT_W     = 12;
    localparam int unsigned KIND_W    = 3;
    localparam int unsigned CFG_W     = 32;
    localparam int unsigned CFG_AW    = 3;

    localparam logic [CNT_W-1:0] STUCK_MAX     = 12'hFFF;
    localparam logic [CNT_W-1:0] TIMEOUT_RESET = 12'h800;

    localparam logic [IDX_W-1:0] LINE_PAD    = 4'd0;
    localparam logic [IDX_W-1:0] LINE_ROOT0  = 4'd4;
    localparam logic [IDX_W-1:0] LINE_ROOT1  = 4'd5;
    localparam logic [IDX_W-1:0] LINE_ROOT2  = 4'd6;
    localparam logic [1:0]       TIMER_PAD   = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_RAISE    = 3'd0,
        KIND_MASK     = 3'd1,
        KIND_HANDLER  = 3'd2,
        KIND_DISPATCH = 3'd3,
        KIND_STOP     = 3'd4,
        KIND_RESTART  = 3'd5,
        KIND_INIT     = 3'd6
    } t_kind;

    typedef enum logic [KIND_W-1:0] {
        RK_LINE    = 3'd0,
        RK_DONE    = 3'd1,
        RK_TIMEOUT = 3'd2,
        RK_UNEXP   = 3'd3,
        RK_OPDONE  = 3'd4
    } t_rkind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_HCMP,
        ST_SCAN,
        ST_SRD,
        ST_STUCK
    } t_state;

    typedef struct packed {
        logic       valid;
        logic       pad;
        logic [1:0] timer;
        logic       flag;
    } t_clear;

endpackage
`default_nettype wire

>>> rtl/core/idc_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration register port
// Holds the timeout limit and serves APB reads and writes.
// ----------------------------------------------------------------------------
module idc_apb_regs
    import idc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_W-1:0]  pwdata,
    output logic      [CFG_W-1:0]  prdata,
    output logic                   pready,
    output logic      [CNT_W-1:0]  o_timeout_limit
);

    logic [CNT_W-1:0] r_timeout_limit;
    logic [CNT_W-1:0] n_timeout_limit;
    logic             w_sel_limit;

    assign w_sel_limit = (paddr[CFG_AW-1] == 1'b0);

    always_comb begin
        n_timeout_limit = r_timeout_limit;
        if (psel && penable && pwrite && w_sel_limit) begin
            n_timeout_limit = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_limit <= TIMEOUT_RESET;
        end else begin
            r_timeout_limit <= n_timeout_limit;
        end
    end

    assign pready          = 1'b1;
    assign prdata          = w_sel_limit ? CFG_W'(r_timeout_limit) : '0;
    assign o_timeout_limit = r_timeout_limit;

endmodule
`default_nettype wire

>>> rtl/core/idc_handler_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Handler table
// One write port and one registered read port; per-entry valid bits make
// unwritten or cleared entries read as zero.
// ----------------------------------------------------------------------------
module idc_handler_ram
    import idc_pkg::*;
#(
    parameter int unsigned NUM_LINES = 11,
    parameter int unsigned LW        = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_rd_en,
    input  wire logic [LW-1:0]    i_rd_addr,
    input  wire logic             i_wr_en,
    input  wire logic [LW-1:0]    i_wr_addr,
    input  wire logic [HND_W-1:0] i_wr_data,
    input  wire logic             i_clr,
    output logic      [HND_W-1:0] o_rdata
);

    logic [HND_W-1:0]     r_mem [NUM_LINES];
    logic [NUM_LINES-1:0] r_valid;
    logic [HND_W-1:0]     r_rdata;
    logic                 r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_clr) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rvalid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule
`default_nettype wire

>>> rtl/core/idc_cmp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared compare unit
// Equality and unsigned greater-than on two operands chosen by the sequencer.
// ----------------------------------------------------------------------------
module idc_cmp
    import idc_pkg::*;
(
    input  wire logic [CMP_W-1:0] i_a,
    input  wire logic [CMP_W-1:0] i_b,
    output logic                  o_eq,
    output logic                  o_gt
);

    assign o_eq = (i_a == i_b);
    assign o_gt = (i_a > i_b);

endmodule
`default_nettype wire

>>> rtl/core/idc_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dispatch sequencer
// Decodes transactions, walks lines one per cycle but pauses at pending ones,
// drives the handler table and shared compare unit, holds the result register.
// ----------------------------------------------------------------------------
module idc_engine
    import idc_pkg::*;
#(
    parameter int unsigned NUM_LINES = 11,
    parameter int unsigned LW        = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [KIND_W-1:0]    i_kind,
    input  wire logic [NUM_LINES-1:0] i_raise,
    input  wire logic [NUM_LINES-1:0] i_nmask,
    input  wire logic [IDX_W-1:0]     i_idx,
    input  wire logic [HND_W-1:0]     i_hnd,
    input  wire logic [CNT_W-1:0]     i_limit,
    output logic                      o_res_valid,
    input  wire logic                 i_res_ready,
    output t_rkind                    o_res_kind,
    output logic      [IDX_W-1:0]     o_res_line,
    output logic      [HND_W-1:0]     o_res_hnd,
    output logic      [NUM_LINES-1:0] o_res_prev,
    output logic      [NUM_LINES-1:0] o_res_snap,
    output t_clear                    o_res_clr,
    output logic                      o_res_last,
    output logic                      o_rd_en,
    output logic      [LW-1:0]        o_rd_addr,
    output logic                      o_wr_en,
    output logic      [LW-1:0]        o_wr_addr,
    output logic      [HND_W-1:0]     o_wr_data,
    output logic                      o_clr,
    input  wire logic [HND_W-1:0]     i_rdata
);

    t_state               r_state, n_state;
    logic [KIND_W-1:0]    r_kind, n_kind;
    logic [NUM_LINES-1:0] r_raise, n_raise;
    logic [NUM_LINES-1:0] r_nmask, n_nmask;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [HND_W-1:0]     r_hnd, n_hnd;
    logic                 r_init, n_init;
    logic [NUM_LINES-1:0] r_en, n_en;
    logic [NUM_LINES-1:0] r_mask, n_mask;
    logic [NUM_LINES-1:0] r_status, n_status;
    logic [NUM_LINES-1:0] r_saved, n_saved;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [NUM_LINES-1:0] r_pend, n_pend;
    logic [LW-1:0]        r_line, n_line;

    logic                 r_ovalid, n_ovalid;
    t_rkind               r_orkind, n_orkind;
    logic [IDX_W-1:0]     r_oline, n_oline;
    logic [HND_W-1:0]     r_ohnd, n_ohnd;
    logic [NUM_LINES-1:0] r_oprev, n_oprev;
    logic [NUM_LINES-1:0] r_osnap, n_osnap;
    t_clear               r_oclr, n_oclr;
    logic                 r_olast, n_olast;

    logic                 w_ofree;
    logic                 w_idx_ok;
    logic                 w_last_line;
    logic [LW-1:0]        w_idx;
    logic [NUM_LINES-1:0] w_bit;
    logic [CMP_W-1:0]     w_cmp_a;
    logic [CMP_W-1:0]     w_cmp_b;
    logic                 w_eq;
    logic                 w_gt;

    assign w_ofree     = !r_ovalid || i_res_ready;
    assign w_idx_ok    = ({1'b0, r_idx} < (IDX_W + 1)'(NUM_LINES));
    assign w_idx       = r_idx[LW-1:0];
    assign w_bit       = NUM_LINES'(1) << w_idx;
    assign w_last_line = (r_line == LW'(NUM_LINES - 1));

    always_comb begin
        if (r_state == ST_STUCK) begin
            w_cmp_a = CMP_W'(r_count);
            w_cmp_b = CMP_W'(i_limit);
        end else begin
            w_cmp_a = r_hnd;
            w_cmp_b = i_rdata;
        end
    end

    idc_cmp u_cmp (
        .i_a  (w_cmp_a),
        .i_b  (w_cmp_b),
        .o_eq (w_eq),
        .o_gt (w_gt)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_ofree) begin
                    if (r_kind == KIND_HANDLER && w_idx_ok && r_init) begin
                        n_state = ST_HCMP;
                    end else if (r_kind == KIND_DISPATCH && r_init) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_HCMP: begin
                if (w_ofree) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (r_pend[r_line]) begin
                    n_state = ST_SRD;
                end else if (w_last_line) begin
                    n_state = ST_STUCK;
                end
            end
            ST_SRD: begin
                if (w_ofree) begin
                    n_state = w_last_line ? ST_STUCK : ST_SCAN;
                end
            end
            ST_STUCK: begin
                if (w_ofree) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_rd_en   = 1'b0;
        o_rd_addr = r_line;
        o_wr_en   = 1'b0;
        o_clr     = 1'b0;
        case (r_state)
            ST_EXEC: begin
                if (r_kind == KIND_HANDLER && w_idx_ok) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = w_idx;
                end
                if (r_kind == KIND_INIT && !r_init && w_ofree) begin
                    o_clr = 1'b1;
                end
            end
            ST_HCMP: begin
                o_wr_en = w_ofree && !w_eq;
            end
            ST_SCAN: begin
                o_rd_en = r_pend[r_line];
            end
            default: ;
        endcase
    end

    assign o_wr_addr = w_idx;
    assign o_wr_data = r_hnd;

    always_comb begin
        n_kind   = r_kind;
        n_raise  = r_raise;
        n_nmask  = r_nmask;
        n_idx    = r_idx;
        n_hnd    = r_hnd;
        n_init   = r_init;
        n_en     = r_en;
        n_mask   = r_mask;
        n_status = r_status;
        n_saved  = r_saved;
        n_count  = r_count;
        n_pend   = r_pend;
        n_line   = r_line;
        n_ovalid = r_ovalid && !i_res_ready;
        n_orkind = r_orkind;
        n_oline  = r_oline;
        n_ohnd   = r_ohnd;
        n_oprev  = r_oprev;
        n_osnap  = r_osnap;
        n_oclr   = r_oclr;
        n_olast  = r_olast;

        if (w_ofree && (r_state == ST_EXEC || r_state == ST_HCMP
                        || r_state == ST_SRD || r_state == ST_STUCK)) begin
            n_ovalid = 1'b1;
            n_orkind = RK_OPDONE;
            n_oline  = '0;
            n_ohnd   = '0;
            n_oprev  = '0;
            n_osnap  = '0;
            n_oclr   = '0;
            n_olast  = 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = i_kind;
                    n_raise = i_raise;
                    n_nmask = i_nmask;
                    n_idx   = i_idx;
                    n_hnd   = i_hnd;
                end
            end
            ST_EXEC: begin
                if (w_ofree) begin
                    case (r_kind)
                        KIND_RAISE: n_status = r_status | r_raise;
                        KIND_MASK: begin
                            n_oprev = r_mask;
                            n_mask  = r_nmask;
                        end
                        KIND_HANDLER: begin
                            if (w_idx_ok && r_init) begin
                                n_ovalid = r_ovalid && !i_res_ready;
                            end
                        end
                        KIND_DISPATCH: begin
                            if (!r_init) begin
                                n_orkind = RK_UNEXP;
                                n_osnap  = r_status;
                            end else begin
                                n_ovalid = r_ovalid && !i_res_ready;
                                n_pend   = r_mask & r_en & r_status;
                                n_line   = '0;
                            end
                        end
                        KIND_STOP: begin
                            if (r_init) begin
                                n_saved  = r_mask;
                                n_mask   = '0;
                                n_status = '0;
                                n_init   = 1'b0;
                            end
                        end
                        KIND_RESTART: begin
                            if (!r_init) begin
                                n_init = 1'b1;
                                n_mask = r_saved;
                            end
                        end
                        KIND_INIT: begin
                            if (!r_init) begin
                                n_mask   = '0;
                                n_status = '0;
                                n_en     = '0;
                                n_saved  = '0;
                                n_init   = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_HCMP: begin
                if (w_ofree && !w_eq) begin
                    if (r_hnd == '0) begin
                        n_mask = r_mask & ~w_bit;
                        n_en   = r_en & ~w_bit;
                    end else begin
                        n_mask = r_mask | w_bit;
                        n_en   = r_en | w_bit;
                    end
                    if (r_idx == LINE_PAD) begin
                        n_oclr.valid = 1'b1;
                        n_oclr.pad   = 1'b1;
                        n_oclr.timer = TIMER_PAD;
                        n_oclr.flag  = (r_hnd == '0);
                    end else if (r_idx inside {LINE_ROOT0, LINE_ROOT1, LINE_ROOT2}) begin
                        n_oclr.valid = 1'b1;
                        n_oclr.timer = 2'(r_idx - LINE_ROOT0);
                        n_oclr.flag  = (r_hnd == '0);
                    end
                end
            end
            ST_SCAN: begin
                if (r_pend[r_line]) begin
                    n_status[r_line] = 1'b0;
                end else if (!w_last_line) begin
                    n_line = r_line + LW'(1);
                end
            end
            ST_SRD: begin
                if (w_ofree) begin
                    n_orkind = RK_LINE;
                    n_oline  = IDX_W'(r_line);
                    n_ohnd   = i_rdata;
                    n_olast  = 1'b0;
                    if (!w_last_line) begin
                        n_line = r_line + LW'(1);
                    end
                end
            end
            ST_STUCK: begin
                if (w_ofree) begin
                    if ((r_status & r_mask) == '0) begin
                        n_count  = '0;
                        n_orkind = RK_DONE;
                    end else if (w_gt) begin
                        n_orkind = RK_TIMEOUT;
                        n_osnap  = r_status;
                        n_count  = '0;
                        n_status = '0;
                    end else begin
                        if (r_count != STUCK_MAX) begin
                            n_count = r_count + CNT_W'(1);
                        end
                        n_orkind = RK_DONE;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_init   <= 1'b0;
            r_en     <= '0;
            r_mask   <= '0;
            r_status <= '0;
            r_saved  <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_init   <= n_init;
            r_en     <= n_en;
            r_mask   <= n_mask;
            r_status <= n_status;
            r_saved  <= n_saved;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_raise  <= n_raise;
        r_nmask  <= n_nmask;
        r_idx    <= n_idx;
        r_hnd    <= n_hnd;
        r_pend   <= n_pend;
        r_line   <= n_line;
        r_orkind <= n_orkind;
        r_oline  <= n_oline;
        r_ohnd   <= n_ohnd;
        r_oprev  <= n_oprev;
        r_osnap  <= n_osnap;
        r_oclr   <= n_oclr;
        r_olast  <= n_olast;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = r_ovalid;
    assign o_res_kind  = r_orkind;
    assign o_res_line  = r_oline;
    assign o_res_hnd   = r_ohnd;
    assign o_res_prev  = r_oprev;
    assign o_res_snap  = r_osnap;
    assign o_res_clr   = r_oclr;
    assign o_res_last  = r_olast;

endmodule
`default_nettype wire

>>> rtl/core/interrupt_dispatch_controller_core.sv
// A non-dispatch transaction has its result registered in the execute state once the output
// is free, a handler update in the compare state after it. A dispatch is paced by the line
// scan, which visits one line per cycle but waits on the output at each serviced line.
// Throughput: the next transaction is accepted the cycle after the last result is registered.
// Reset is synchronous and active low; it clears the control state and the handler table
// valid bits at once and sets the timeout limit to 2048.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Interrupt dispatch controller
// Status, mask, enable set and handler table with a sequential dispatch scan.
// ----------------------------------------------------------------------------
module interrupt_dispatch_controller_core
    import idc_pkg::*;
#(
    parameter int unsigned NUM_LINES = 11
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // raise_lines, new_mask, irq_index, handler_address, zero fill
    input  wire logic [((2*NUM_LINES+36+7)/8)*8-1:0] s_axis_tdata,
    // kind
    input  wire logic [KIND_W-1:0]  s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // line_number, handler_out, previous_mask, status_snapshot, clear_valid,
    // clear_pad, clear_timer, clear_flag, zero fill
    output logic [((2*NUM_LINES+41+7)/8)*8-1:0] m_axis_tdata,
    // result_kind
    output logic      [KIND_W-1:0]  m_axis_tuser,
    output logic                    m_axis_tlast,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [CFG_AW-1:0]  paddr,
    input  wire logic [CFG_W-1:0]   pwdata,
    output logic      [CFG_W-1:0]   prdata,
    output logic                    pready
);

    localparam int unsigned LW    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int unsigned OUT_W = ((2*NUM_LINES+41+7)/8)*8;

    logic [CNT_W-1:0]     w_limit;
    logic                 w_rd_en;
    logic [LW-1:0]        w_rd_addr;
    logic                 w_wr_en;
    logic [LW-1:0]        w_wr_addr;
    logic [HND_W-1:0]     w_wr_data;
    logic                 w_clr;
    logic [HND_W-1:0]     w_rdata;
    t_rkind               w_res_kind;
    logic [IDX_W-1:0]     w_res_line;
    logic [HND_W-1:0]     w_res_hnd;
    logic [NUM_LINES-1:0] w_res_prev;
    logic [NUM_LINES-1:0] w_res_snap;
    t_clear               w_res_clr;

    idc_apb_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_timeout_limit (w_limit)
    );

    idc_handler_ram #(
        .NUM_LINES (NUM_LINES),
        .LW        (LW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_clr     (w_clr),
        .o_rdata   (w_rdata)
    );

    idc_engine #(
        .NUM_LINES (NUM_LINES),
        .LW        (LW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_raise     (s_axis_tdata[NUM_LINES-1:0]),
        .i_nmask     (s_axis_tdata[2*NUM_LINES-1:NUM_LINES]),
        .i_idx       (s_axis_tdata[2*NUM_LINES+IDX_W-1:2*NUM_LINES]),
        .i_hnd       (s_axis_tdata[2*NUM_LINES+IDX_W+HND_W-1:2*NUM_LINES+IDX_W]),
        .i_limit     (w_limit),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res_kind  (w_res_kind),
        .o_res_line  (w_res_line),
        .o_res_hnd   (w_res_hnd),
        .o_res_prev  (w_res_prev),
        .o_res_snap  (w_res_snap),
        .o_res_clr   (w_res_clr),
        .o_res_last  (m_axis_tlast),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_clr       (w_clr),
        .i_rdata     (w_rdata)
    );

    assign m_axis_tuser = w_res_kind;
    assign m_axis_tdata = OUT_W'({w_res_clr.flag, w_res_clr.timer, w_res_clr.pad,
                                 w_res_clr.valid, w_res_snap, w_res_prev,
                                 w_res_hnd, w_res_line});

endmodule
`default_nettype wire
